// ----- rtl/des_rf_pkg.sv -----
// Shared tables and bit-level helpers for the DES round function pipeline.
// Holds the E, P and S-box tables and the expand, S-box lookup and permute functions.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package des_rf_pkg;

  typedef logic [31:0]  half_t;
  typedef logic [47:0]  key_t;
  typedef logic [127:0] cand_t;   // four row candidates per S-box, S1 row 0 on top
  typedef logic [15:0]  rows_t;   // row number per S-box, S1 on top

  // Expansion E: 1-based DES bit numbers of the right half (bit 1 = MSB).
  localparam logic [5:0] EXP_TAB [0:47] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  // Permutation P: 1-based DES bit numbers of the S-box output.
  localparam logic [5:0] PERM_TAB [0:31] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // S-boxes, indexed [box][row * 16 + column].
  localparam logic [3:0] SBOX_TAB [0:7][0:63] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  // E expansion: DES bit n of the half sits at vector index 32 - n.
  function automatic key_t expand(input half_t r);
    key_t e;
    e = '0;
    for (int i = 0; i < 48; i++) begin
      e[47 - i] = r[5'(6'd32 - EXP_TAB[i])];
    end
    return e;
  endfunction

  // Column lookup: the inner four bits of each group pick one entry in every row.
  function automatic cand_t lookup_cols(input key_t x);
    cand_t      c;
    logic [5:0] six;
    c   = '0;
    six = '0;
    for (int i = 0; i < 8; i++) begin
      six = x[47 - 6*i -: 6];
      for (int row = 0; row < 4; row++) begin
        c[127 - 16*i - 4*row -: 4] = SBOX_TAB[i][{2'(row), six[4:1]}];
      end
    end
    return c;
  endfunction

  // Outer bits of each group, the row number of its S-box.
  function automatic rows_t outer_bits(input key_t x);
    rows_t rs;
    rs = '0;
    for (int i = 0; i < 8; i++) begin
      rs[15 - 2*i -: 2] = {x[47 - 6*i], x[42 - 6*i]};
    end
    return rs;
  endfunction

  // Row select: keep the candidate of the row that the outer bits name.
  function automatic half_t pick_rows(input cand_t c, input rows_t rs);
    half_t      s;
    logic [1:0] row;
    s   = '0;
    row = '0;
    for (int i = 0; i < 8; i++) begin
      row = rs[15 - 2*i -: 2];
      case (row)
        2'd0:    s[31 - 4*i -: 4] = c[127 - 16*i -: 4];
        2'd1:    s[31 - 4*i -: 4] = c[123 - 16*i -: 4];
        2'd2:    s[31 - 4*i -: 4] = c[119 - 16*i -: 4];
        default: s[31 - 4*i -: 4] = c[115 - 16*i -: 4];
      endcase
    end
    return s;
  endfunction

  // P permutation.
  function automatic half_t permute(input half_t s);
    half_t p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      p[31 - i] = s[5'(6'd32 - PERM_TAB[i])];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/des_round_function.sv -----
// DES round function f(R, K) as a three-stage pipeline with valid/ready handshakes.
// Depends on des_rf_pkg for the E, S-box and P tables and helpers.
//
// Usage:
//   Input channel: in_valid / in_ready carry one transaction of in_right_half
//   (32 bits) and in_round_subkey (48 bits), DES bit 1 in the MSB.
//   Result channel: out_valid / out_ready carry out_f_output (32 bits),
//   P(S(E(R) xor K)), one result per input transaction, in order.
//   Stages: expand/key mix, S-box column lookup, S-box row select and P
//   permutation, one stage each.
//   Throughput: one transaction per cycle, sustained, while out_ready is high.
//   Each stage holds its own valid bit; a bubble in the pipe is filled even
//   while the output waits, so in_ready falls only when all three stages are
//   full and the receiver stalls.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers are
//   not reset. No configuration: the block holds no state between transactions.
`timescale 1ns / 1ps
`default_nettype none

module des_round_function (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire des_rf_pkg::half_t in_right_half,
  input  wire des_rf_pkg::key_t  in_round_subkey,
  output logic                  out_valid,
  input  wire                   out_ready,
  output des_rf_pkg::half_t     out_f_output
);
  import des_rf_pkg::*;

  // Stage valid bits and payload registers.
  logic  v1_r, v2_r, v3_r;
  logic  v1_nxt, v2_nxt, v3_nxt;
  key_t  x1_r, x1_nxt;   // E(R) xor K
  cand_t c2_r, c2_nxt;   // every row's S-box entry for each group's column
  rows_t r2_r, r2_nxt;   // row number of each group
  half_t p3_r, p3_nxt;   // permuted result

  // A stage may load when it is empty or its content moves on this cycle.
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid    = v3_r;
  assign out_f_output = p3_r;

  always_comb begin
    // Hold by default; advance a stage only when the one after it can take it.
    v1_nxt = v1_r;
    x1_nxt = x1_r;
    v2_nxt = v2_r;
    c2_nxt = c2_r;
    r2_nxt = r2_r;
    v3_nxt = v3_r;
    p3_nxt = p3_r;

    if (rdy1) begin
      v1_nxt = in_valid;
      x1_nxt = expand(in_right_half) ^ in_round_subkey;
    end
    if (rdy2) begin
      v2_nxt = v1_r;
      c2_nxt = lookup_cols(x1_r);
      r2_nxt = outer_bits(x1_r);
    end
    if (rdy3) begin
      v3_nxt = v2_r;
      p3_nxt = permute(pick_rows(c2_r, r2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt;
    c2_r <= c2_nxt;
    r2_r <= r2_nxt;
    p3_r <= p3_nxt;
  end

  // Reset empties the whole pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline not empty after reset");

  // An accepted transaction always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction lost at stage 1");

  // Stage 1 content moves to stage 2 when stage 2 can take it.
  a_stage1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && rdy2 |=> v2_r)
    else $error("stage 1 transaction lost");

  // A blocked middle stage keeps its data.
  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(c2_r) && $stable(r2_r))
    else $error("stalled stage 2 changed");

  // Backpressure reaches the input only when every stage is full.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && !out_ready)
    else $error("in_ready low with a free stage");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for des_round_function: drives (R, K) transactions and scores f(R, K).
// Depends on des_rf_pkg for the port types only; the expected values come from an
// independent bit-level predictor kept in the scoreboard class below.
`timescale 1ns / 1ps

module testbench;
  import des_rf_pkg::half_t;
  import des_rf_pkg::key_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  // Scoreboard: predicts f(R, K) for every accepted input transaction and
  // checks the results in order.
  class FRoundBoard;
    // S-box rows, 16 nibbles each, first column in the top nibble.
    localparam logic [255:0] SBOX_ROWS [0:7] = '{
      {64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D},
      {64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9},
      {64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C},
      {64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E},
      {64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453},
      {64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D},
      {64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C},
      {64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B}
    };
    // P: source bit (DES numbering, 1 = MSB) for each output bit.
    localparam int PERM_SRC [0:31] = '{
      16,  7, 20, 21, 29, 12, 28, 17,  1, 15, 23, 26,  5, 18, 31, 10,
       2,  8, 24, 14, 32, 27,  3,  9, 19, 13, 30,  6, 22, 11,  4, 25
    };

    half_t expected_f[$];
    int    mismatches;

    function new();
      mismatches = 0;
    endfunction

    // E: group g takes DES bits 4g .. 4g+5 of R, wrapping 0 -> 32 and 33 -> 1.
    function half_t f_round(half_t r, key_t k);
      key_t       mixed;
      half_t      sub;
      half_t      res;
      logic [5:0] six;
      int         src;
      int         idx;
      for (int g = 0; g < 8; g++) begin
        for (int j = 0; j < 6; j++) begin
          src = ((4 * g + j + 31) % 32) + 1;
          mixed[47 - (6 * g + j)] = r[32 - src];
        end
      end
      mixed ^= k;
      for (int g = 0; g < 8; g++) begin
        six = mixed[47 - 6 * g -: 6];
        idx = {six[5], six[0], six[4:1]};
        sub[31 - 4 * g -: 4] = SBOX_ROWS[g][255 - 4 * idx -: 4];
      end
      for (int i = 0; i < 32; i++) begin
        res[31 - i] = sub[32 - PERM_SRC[i]];
      end
      return res;
    endfunction

    function void note_block(half_t r, key_t k);
      expected_f = {expected_f, f_round(r, k)};
    endfunction

    function void check_result(half_t got);
      half_t want;
      if (expected_f.size() == 0) begin
        $error("f_output: unexpected result %h with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = expected_f.pop_front();
      if (got !== want) begin
        $error("f_output mismatch: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_f.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  half_t in_right_half = '0;
  key_t  in_round_subkey = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  half_t out_f_output;

  int send_idle_pct = 33;
  int recv_idle_pct = 68;
  int cycle_count = 0;

  FRoundBoard f_board = new();

  des_round_function dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_right_half   (in_right_half),
    .in_round_subkey (in_round_subkey),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_f_output    (out_f_output)
  );

  always #6 clk = ~clk;

  // Stall the receiver at random; a zero percentage gives a stall-free stretch.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sample both channels with pre-edge values: note accepted inputs, score results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        f_board.note_block(in_right_half, in_round_subkey);
      end
      if (out_valid && out_ready) begin
        f_board.check_result(out_f_output);
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** des_round_function: FAILED **");
      $finish;
    end
  end

  // Present one transaction, idling first at the sender's rate, and hold it
  // until the edge that accepts it. Call only right after a rising edge.
  task automatic send_block(input half_t r, input key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_right_half   <= r;
    in_round_subkey <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every outstanding result to come back; step one
  // edge first so the last accepted transaction has been noted.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (f_board.outstanding() != 0) @(posedge clk);
  endtask

  // Mix fully random transactions with sparse and saturated ones so single
  // bits and whole S-box groups get exercised.
  task automatic send_random_block();
    half_t r;
    key_t  k;
    r = $urandom;
    k = {16'($urandom), 32'($urandom)};
    case ($urandom_range(7))
      0: r = half_t'(1) << $urandom_range(31);
      1: k = key_t'(1) << $urandom_range(47);
      2: r = '0;
      3: r = '1;
      4: k = '0;
      5: k = '1;
      default: ;
    endcase
    send_block(r, k);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, alternating patterns, single bits at both ends,
    // and the textbook first-round vector.
    send_block(32'h0000_0000, 48'h0000_0000_0000);
    send_block(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_block(32'hFFFF_FFFF, 48'h0000_0000_0000);
    send_block(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_block(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    send_block(32'hAAAA_AAAA, 48'h5555_5555_5555);
    send_block(32'h8000_0000, 48'h0000_0000_0000);
    send_block(32'h0000_0001, 48'h0000_0000_0000);
    send_block(32'h0000_0000, 48'h8000_0000_0000);
    send_block(32'h0000_0000, 48'h0000_0000_0001);
    send_block(32'h0F0F_0F0F, 48'hF0F0_F0F0_F0F0);
    send_block(32'hF0AA_F0AA, 48'h1B02_EFFC_7072);
    send_block(32'h1234_5678, 48'h9ABC_DEF0_1234);

    // Phase 1: sender idles lightly, receiver stalls heavily.
    repeat (520) send_random_block();

    // Hold the sender off until the pipe is empty, then resume.
    drain_results();
    @(posedge clk);

    // Phase 2: roles swapped.
    send_idle_pct = 68;
    recv_idle_pct = 33;
    repeat (530) send_random_block();

    // Phase 3: back-to-back at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (540) send_random_block();

    drain_results();
    // Watch a little longer for stray results.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (f_board.mismatches == 0 && f_board.outstanding() == 0) begin
      $display("** des_round_function: PASSED **");
    end else begin
      $display("** des_round_function: FAILED **");
    end
    $finish;
  end

endmodule
